/* rtl/bcc_pkg.sv */
// Shared types, constants and helpers for the BGRA canvas compositor.
// No dependencies; every other file of the block imports this package.
package bcc_pkg;

  localparam int ACT_W      = 2;
  localparam int POS_W      = 13;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 4 * CH_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIM_W      = 9;
  localparam int OFS_W      = 16;
  localparam int KEY_W      = 24;
  localparam int COORD_W    = 18;   // signed offset plus frame-local position
  localparam int LIN_W      = 27;   // linear address before truncation
  localparam int Q_DEPTH    = 2;

  localparam int DEF_MAX_CANVAS_WIDTH  = 256;
  localparam int DEF_MAX_CANVAS_HEIGHT = 256;

  localparam logic [DIM_W-1:0] RST_CANVAS_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0] RST_CANVAS_HEIGHT = 9'd256;

  localparam logic [CH_W-1:0] CH_MAX    = 8'hFF;
  localparam logic [15:0]     ROUND_ADD = 16'd127;
  localparam logic [31:0]     RECIP_255 = 32'd32897;   // ceil(2^23 / 255)

  typedef enum logic [ACT_W-1:0] {
    ACT_COMPOSITE = 2'd0,
    ACT_CLEAR     = 2'd1,
    ACT_READ      = 2'd2
  } bcc_act_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CANVAS_WIDTH  = 3'd0,
    CFG_CANVAS_HEIGHT = 3'd1,
    CFG_FRAME_LEFT    = 3'd2,
    CFG_FRAME_TOP     = 3'd3,
    CFG_KEY_COLOR     = 3'd4,
    CFG_KEY_ENABLE    = 3'd5,
    CFG_FORCE_OPAQUE  = 3'd6
  } bcc_cfg_idx_t;

  // Commands that travel from the front end to the store engine
  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,   // store the pixel word as is (copy or clear)
    OP_BLEND    = 2'd1,   // read, blend over, write back
    OP_READ     = 2'd2,   // read and return
    OP_READ_OUT = 2'd3    // read outside the canvas: return zeros
  } bcc_op_t;

  typedef struct packed {
    bcc_op_t          op;
    logic [PIX_W-1:0] pixel;   // {A, R, G, B}
  } bcc_cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0]        canvas_width;
    logic [DIM_W-1:0]        canvas_height;
    logic signed [OFS_W-1:0] frame_left;
    logic signed [OFS_W-1:0] frame_top;
    logic [KEY_W-1:0]        key_color;
    logic                    key_enable;
    logic                    force_opaque;
  } bcc_cfg_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  alpha;
  } bcc_item_t;

  // Rounded division by 255 of a product d*(255-a); exact for every 8x8 product
  function automatic logic [CH_W-1:0] div255_round(input logic [15:0] prod);
    logic [15:0] v;
    logic [31:0] m;
    v = prod + ROUND_ADD;
    m = 32'(v) * RECIP_255;
    return m[30:23];
  endfunction

endpackage

/* rtl/bcc_in_if.sv */
// Input channel of the canvas compositor: valid/ready plus one action item.
// Depends on bcc_pkg for field widths.
interface bcc_in_if import bcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [CH_W-1:0]  blue;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  alpha;

  modport source (output valid, action, pos_x, pos_y, blue, green, red, alpha,
                  input ready);
  modport sink   (input valid, action, pos_x, pos_y, blue, green, red, alpha,
                  output ready);
endinterface

/* rtl/bcc_out_if.sv */
// Result channel of the canvas compositor: valid/ready plus one read pixel.
// Depends on bcc_pkg for field widths.
interface bcc_out_if import bcc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_alpha;
  logic            out_inside;

  modport source (output valid, out_blue, out_green, out_red, out_alpha, out_inside,
                  input ready);
  modport sink   (input valid, out_blue, out_green, out_red, out_alpha, out_inside,
                  output ready);
endinterface

/* rtl/bcc_cfg_if.sv */
// Configuration write channel of the canvas compositor: valid/ready, index, data.
// Depends on bcc_pkg for field widths.
interface bcc_cfg_if import bcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

/* rtl/bgra_canvas_compositor_core.sv */
// Top level of the BGRA canvas compositor: configuration registers, front end,
// command queue and store engine. Depends on bcc_pkg, the three channel interfaces,
// bcc_front, bcc_queue and bcc_back.
//
// The block keeps a MAX_CANVAS_WIDTH x MAX_CANVAS_HEIGHT canvas of 32-bit premultiplied
// BGRA pixels. Each item composites a pixel over the canvas (offset by frame_left /
// frame_top and clipped), clears one pixel, or reads one back; only reads return a
// result. After reset the store is swept to zero, one word per cycle, over all
// MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT words (65536 by default); in_ch.ready stays low
// during the sweep, while configuration writes are taken at any time. The front end
// registers an item and clips it from that register; a two-entry queue then feeds the
// store engine, which owns the canvas memory (one write port, one registered read port)
// and runs one item at a time: a copy, clear or fully opaque composite is written from
// idle, a read goes through memory read and readout register, and a partial-alpha
// blend through read, multiply, then divide and write back. Dropped items (off canvas,
// zero alpha, unused action code) never reach the engine. The engine's read-modify-write
// sequence sets the sustained rate. Configure only while the block is idle.
module bgra_canvas_compositor_core import bcc_pkg::*; #(
  parameter int MAX_CANVAS_WIDTH  = DEF_MAX_CANVAS_WIDTH,
  parameter int MAX_CANVAS_HEIGHT = DEF_MAX_CANVAS_HEIGHT
) (
  input  logic      clk,
  input  logic      rst_n,
  bcc_in_if.sink    in_ch,
  bcc_out_if.source out_ch,
  bcc_cfg_if.sink   cfg_ch
);

  localparam int DEPTH  = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bcc_cfg_t          cfg_r;
  logic              clearing;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  bcc_cmd_t          push_cmd;
  logic [ADDR_W-1:0] push_addr;
  bcc_cmd_t          head_cmd;
  logic [ADDR_W-1:0] head_addr;

  // Registers take writes at any time; unknown indexes are dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.canvas_width  <= RST_CANVAS_WIDTH;
      cfg_r.canvas_height <= RST_CANVAS_HEIGHT;
      cfg_r.frame_left    <= '0;
      cfg_r.frame_top     <= '0;
      cfg_r.key_color     <= '0;
      cfg_r.key_enable    <= 1'b0;
      cfg_r.force_opaque  <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (bcc_cfg_idx_t'(cfg_ch.addr))
        CFG_CANVAS_WIDTH:  cfg_r.canvas_width  <= cfg_ch.data[DIM_W-1:0];
        CFG_CANVAS_HEIGHT: cfg_r.canvas_height <= cfg_ch.data[DIM_W-1:0];
        CFG_FRAME_LEFT:    cfg_r.frame_left    <= cfg_ch.data[OFS_W-1:0];
        CFG_FRAME_TOP:     cfg_r.frame_top     <= cfg_ch.data[OFS_W-1:0];
        CFG_KEY_COLOR:     cfg_r.key_color     <= cfg_ch.data[KEY_W-1:0];
        CFG_KEY_ENABLE:    cfg_r.key_enable    <= cfg_ch.data[0];
        CFG_FORCE_OPAQUE:  cfg_r.force_opaque  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Front end: register, offset, clip, classify
  bcc_front #(
    .MAX_CANVAS_WIDTH  (MAX_CANVAS_WIDTH),
    .MAX_CANVAS_HEIGHT (MAX_CANVAS_HEIGHT),
    .ADDR_W            (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .clearing  (clearing),
    .q_full    (q_full),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .push_addr (push_addr)
  );

  // Decouple the front end from the store engine
  bcc_queue #(
    .ADDR_W (ADDR_W),
    .DEPTH  (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .push_addr (push_addr),
    .pop       (q_pop),
    .head_cmd  (head_cmd),
    .head_addr (head_addr),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Store engine: memory, blend and readout
  bcc_back #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_cmd    (head_cmd),
    .q_addr   (head_addr),
    .pop      (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

  // No item may enter while the store is still being swept
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !(in_ch.valid && in_ch.ready))
    else $error("item accepted during clearing pass");

  // The sweep runs once after reset and never restarts
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clearing |=> !clearing)
    else $error("clearing pass restarted");

  // The front end never pushes into a full queue
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command queue overflow");

endmodule

/* rtl/bcc_front.sv */
// Front end: accepts action items, offsets and clips them, and turns them into store commands.
// Depends on bcc_pkg and bcc_in_if.
module bcc_front import bcc_pkg::*; #(
  parameter int MAX_CANVAS_WIDTH  = DEF_MAX_CANVAS_WIDTH,
  parameter int MAX_CANVAS_HEIGHT = DEF_MAX_CANVAS_HEIGHT,
  parameter int ADDR_W            = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  bcc_in_if.sink            in_ch,
  input  bcc_cfg_t          cfg,
  input  logic              clearing,
  input  logic              q_full,
  output logic              push,
  output bcc_cmd_t          push_cmd,
  output logic [ADDR_W-1:0] push_addr
);

  localparam logic [COORD_W-2:0] MAX_W = (COORD_W-1)'(MAX_CANVAS_WIDTH);
  localparam logic [COORD_W-2:0] MAX_H = (COORD_W-1)'(MAX_CANVAS_HEIGHT);

  logic                      stage_valid_r;
  bcc_item_t                 item_r;
  logic                      drop;
  logic                      stage_done;
  logic                      accept;
  logic [COORD_W-2:0]        eff_w;
  logic [COORD_W-2:0]        eff_h;
  logic signed [COORD_W-1:0] xs;
  logic signed [COORD_W-1:0] ys;
  logic                      on_canvas;
  logic [LIN_W-1:0]          lin;

  // Clamp the configured size to the store's size
  always_comb begin
    eff_w = ((COORD_W-1)'(cfg.canvas_width) > MAX_W) ? MAX_W
                                                     : (COORD_W-1)'(cfg.canvas_width);
    eff_h = ((COORD_W-1)'(cfg.canvas_height) > MAX_H) ? MAX_H
                                                      : (COORD_W-1)'(cfg.canvas_height);
  end

  // Canvas position: offset by the frame origin except for reads
  always_comb begin
    if (bcc_act_t'(item_r.action) == ACT_READ) begin
      xs = COORD_W'(item_r.pos_x);
      ys = COORD_W'(item_r.pos_y);
    end else begin
      xs = COORD_W'(cfg.frame_left) + COORD_W'(item_r.pos_x);
      ys = COORD_W'(cfg.frame_top) + COORD_W'(item_r.pos_y);
    end
    on_canvas = !xs[COORD_W-1] && !ys[COORD_W-1] &&
                (xs[COORD_W-2:0] < eff_w) && (ys[COORD_W-2:0] < eff_h);
    lin = LIN_W'(ys[POS_W-1:0]) * LIN_W'(MAX_CANVAS_WIDTH) + LIN_W'(xs[POS_W-1:0]);
  end

  // Classify; dropped items never reach the queue
  always_comb begin
    drop           = 1'b1;
    push_cmd.op    = OP_WRITE;
    push_cmd.pixel = {item_r.alpha, item_r.red, item_r.green, item_r.blue};
    unique case (bcc_act_t'(item_r.action))
      ACT_COMPOSITE: begin
        drop        = !on_canvas || (item_r.alpha == '0);
        push_cmd.op = (item_r.alpha == CH_MAX) ? OP_WRITE : OP_BLEND;
      end
      ACT_CLEAR: begin
        drop           = !on_canvas;
        push_cmd.pixel = '0;
      end
      ACT_READ: begin
        drop        = 1'b0;
        push_cmd.op = on_canvas ? OP_READ : OP_READ_OUT;
      end
      default: drop = 1'b1;
    endcase
  end

  assign push_addr   = lin[ADDR_W-1:0];
  assign push        = stage_valid_r && !drop && !q_full;
  assign stage_done  = stage_valid_r && (drop || !q_full);
  assign in_ch.ready = !clearing && (!stage_valid_r || stage_done);
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (accept) begin
      stage_valid_r <= 1'b1;
    end else if (stage_done) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{action: in_ch.action, pos_x: in_ch.pos_x, pos_y: in_ch.pos_y,
                  blue: in_ch.blue, green: in_ch.green, red: in_ch.red,
                  alpha: in_ch.alpha};
    end
  end

endmodule

/* rtl/bcc_queue.sv */
// Short command queue between the front end and the store engine.
// Depends on bcc_pkg for the command type.
module bcc_queue import bcc_pkg::*; #(
  parameter int ADDR_W = 16,
  parameter int DEPTH  = Q_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bcc_cmd_t          push_cmd,
  input  logic [ADDR_W-1:0] push_addr,
  input  logic              pop,
  output bcc_cmd_t          head_cmd,
  output logic [ADDR_W-1:0] head_addr,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bcc_cmd_t          cmd_q  [DEPTH];
  logic [ADDR_W-1:0] addr_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign head_cmd  = cmd_q[rd_ptr_r];
  assign head_addr = addr_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr_r]  <= push_cmd;
      addr_q[wr_ptr_r] <= push_addr;
    end
  end

endmodule

/* rtl/bcc_back.sv */
// Store engine: canvas memory, clearing pass, blend read-modify-write and readout.
// Depends on bcc_pkg and bcc_out_if.
module bcc_back import bcc_pkg::*; #(
  parameter int ADDR_W = 16,
  parameter int DEPTH  = DEF_MAX_CANVAS_WIDTH * DEF_MAX_CANVAS_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bcc_cfg_t          cfg,
  input  logic              q_empty,
  input  bcc_cmd_t          q_cmd,
  input  logic [ADDR_W-1:0] q_addr,
  output logic              pop,
  output logic              clearing,
  bcc_out_if.source         out_ch
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_FETCH = 4'b0100,
    S_MUL   = 4'b1000
  } bcc_bstate_t;

  bcc_bstate_t       state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r;
  bcc_cmd_t          cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PIX_W-1:0]  rd_data_r;
  logic [15:0]       prod_r [4];
  logic [PIX_W-1:0]  mem [DEPTH];

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [PIX_W-1:0]  mem_wdata;
  logic              out_free;
  logic              out_load;
  logic [PIX_W-1:0]  blend_pix;
  logic [PIX_W-1:0]  view_pix;
  logic [CH_W-1:0]   inv_alpha;
  logic [CH_W:0]     alpha_sum;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_inside_r;

  assign clearing  = (state_r == S_CLEAR);
  assign pop       = (state_r == S_IDLE) && !q_empty;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign inv_alpha = CH_MAX - cmd_r.pixel[PIX_W-1 -: CH_W];

  // Blend over: colour wraps, alpha saturates
  always_comb begin
    logic [CH_W-1:0] q [4];
    for (int i = 0; i < 4; i++) begin
      q[i] = div255_round(prod_r[i]);
    end
    for (int i = 0; i < 3; i++) begin
      blend_pix[i*CH_W +: CH_W] = cmd_r.pixel[i*CH_W +: CH_W] + q[i];
    end
    alpha_sum = {1'b0, cmd_r.pixel[PIX_W-1 -: CH_W]} + {1'b0, q[3]};
    blend_pix[PIX_W-1 -: CH_W] = alpha_sum[CH_W] ? CH_MAX : alpha_sum[CH_W-1:0];
  end

  // Readout: force opaque first, then the colour key
  always_comb begin
    view_pix = rd_data_r;
    if (cfg.force_opaque) begin
      view_pix[PIX_W-1 -: CH_W] = CH_MAX;
    end
    if (cfg.key_enable && (view_pix[KEY_W-1:0] == cfg.key_color)) begin
      view_pix[PIX_W-1 -: CH_W] = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = q_addr;
    mem_wdata = q_cmd.pixel;
    out_load  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          if (q_cmd.op == OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (cmd_r.op == OP_BLEND) begin
          state_nxt = S_MUL;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = blend_pix;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r  <= q_cmd;
      addr_r <= q_addr;
    end
    if (state_r == S_FETCH) begin
      for (int i = 0; i < 4; i++) begin
        prod_r[i] <= 16'(rd_data_r[i*CH_W +: CH_W]) * 16'(inv_alpha);
      end
    end
    if (out_load) begin
      out_inside_r <= (cmd_r.op == OP_READ);
      out_pix_r    <= (cmd_r.op == OP_READ) ? view_pix : '0;
    end
  end

  // Canvas memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_data_r <= mem[q_addr];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_blue   = out_pix_r[0 +: CH_W];
  assign out_ch.out_green  = out_pix_r[CH_W +: CH_W];
  assign out_ch.out_red    = out_pix_r[2*CH_W +: CH_W];
  assign out_ch.out_alpha  = out_pix_r[3*CH_W +: CH_W];
  assign out_ch.out_inside = out_inside_r;

endmodule

/* tb/bgra_canvas_compositor_core_test.sv */
// Self-checking testbench for bgra_canvas_compositor_core: drives composite, clear
// and read items, predicts every read result and compares it field by field.
// Depends on bcc_pkg, bcc_in_if, bcc_out_if, bcc_cfg_if and the compositor RTL.
module bgra_canvas_compositor_core_test import bcc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 10;
  localparam int CANVAS_W   = DEF_MAX_CANVAS_WIDTH;
  localparam int CANVAS_H   = DEF_MAX_CANVAS_HEIGHT;
  localparam int IDLE_PCT   = 12;
  // Front register, two queue slots and the blend's read, multiply and write-back states:
  // wait this long after the last read result before touching a register.
  localparam int SETTLE_CYCLES = 24;
  // The reset sweep alone keeps the input closed while it clears all CANVAS_W * CANVAS_H words.
  localparam int STALL_LIMIT = 4 * CANVAS_W * CANVAS_H;
  localparam int HOLD_OFF_CYCLES = 300;

  // Codes the package leaves unnamed
  localparam logic [ACT_W-1:0]      ACT_UNUSED     = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] alpha;
    logic            in_canvas;
  } readback_t;

  logic clk = 1'b0;
  logic rst_n;

  bcc_in_if  in_ch();
  bcc_out_if out_ch();
  bcc_cfg_if cfg_ch();

  bgra_canvas_compositor_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the canvas and of every register
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] pixel_mem [0:CANVAS_W*CANVAS_H-1];   // {A, R, G, B}
  int               width_in_use;
  int               height_in_use;
  int               origin_x;
  int               origin_y;
  logic [KEY_W-1:0] chroma_key;
  bit               chroma_key_on;
  bit               opaque_readout;

  readback_t pending_reads[$];   // read results still owed by the block
  int        mismatches;

  // Stimulus shaping, shared by the sender, the receiver and the tests
  bit steady_flow;     // no idling on either side while set
  int hold_request;    // receiver clears this, then holds ready low this many cycles
  int hot_x;           // random targets fall in [0, hot_x] x [0, hot_y]
  int hot_y;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic bit locate(input int x, input int y, output int addr);
    int span_x;
    int span_y;
    // An oversized register acts as the physical canvas size.
    span_x = (width_in_use > CANVAS_W) ? CANVAS_W : width_in_use;
    span_y = (height_in_use > CANVAS_H) ? CANVAS_H : height_in_use;
    addr = y * CANVAS_W + x;
    return (x >= 0 && y >= 0 && x < span_x && y < span_y);
  endfunction

  function automatic logic [CH_W-1:0] over_channel(input logic [CH_W-1:0] src,
                                                   input logic [CH_W-1:0] dst,
                                                   input int inv);
    int sum;
    sum = int'(src) + (int'(dst) * inv + 127) / 255;
    return sum[CH_W-1:0];   // colour wraps, it does not saturate
  endfunction

  function automatic void apply_reg(input logic [CFG_ADDR_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    unique case (idx)
      CFG_CANVAS_WIDTH:  width_in_use   = int'(data[DIM_W-1:0]);
      CFG_CANVAS_HEIGHT: height_in_use  = int'(data[DIM_W-1:0]);
      CFG_FRAME_LEFT:    origin_x       = int'($signed(data[OFS_W-1:0]));
      CFG_FRAME_TOP:     origin_y       = int'($signed(data[OFS_W-1:0]));
      CFG_KEY_COLOR:     chroma_key     = data[KEY_W-1:0];
      CFG_KEY_ENABLE:    chroma_key_on  = data[0];
      CFG_FORCE_OPAQUE:  opaque_readout = data[0];
      default: ;   // unknown index: drop the write
    endcase
  endfunction

  function automatic void predict_action(input bcc_item_t it);
    int               addr;
    int               inv;
    int               new_alpha;
    logic [PIX_W-1:0] dst;
    readback_t        res;
    unique case (it.action)
      ACT_COMPOSITE: begin
        if (locate(origin_x + int'(it.pos_x), origin_y + int'(it.pos_y), addr) &&
            it.alpha != 8'd0) begin
          if (it.alpha == CH_MAX) begin
            pixel_mem[addr] = {it.alpha, it.red, it.green, it.blue};
          end else begin
            dst = pixel_mem[addr];
            inv = 255 - int'(it.alpha);
            new_alpha = int'(it.alpha) + (int'(dst[31:24]) * inv + 127) / 255;
            if (new_alpha > 255) new_alpha = 255;
            pixel_mem[addr] = {8'(new_alpha), over_channel(it.red, dst[23:16], inv),
                               over_channel(it.green, dst[15:8], inv),
                               over_channel(it.blue, dst[7:0], inv)};
          end
        end
      end
      ACT_CLEAR: begin
        if (locate(origin_x + int'(it.pos_x), origin_y + int'(it.pos_y), addr))
          pixel_mem[addr] = '0;
      end
      ACT_READ: begin
        res = '0;
        if (locate(int'(it.pos_x), int'(it.pos_y), addr)) begin
          dst = pixel_mem[addr];
          // Force opaque first, then the colour key.
          if (opaque_readout) dst[31:24] = CH_MAX;
          if (chroma_key_on && dst[23:0] == chroma_key) dst[31:24] = 8'd0;
          res = '{blue: dst[7:0], green: dst[15:8], red: dst[23:16],
                  alpha: dst[31:24], in_canvas: 1'b1};
        end
        pending_reads = {pending_reads, res};
      end
      default: ;   // unused action code: no result, no state change
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    readback_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_reads.size() == 0) begin
        report_mismatch("unexpected result", int'(out_ch.out_inside), 0);
      end else begin
        want = pending_reads.pop_front();
        if (out_ch.out_blue !== want.blue)
          report_mismatch("out_blue", int'(out_ch.out_blue), int'(want.blue));
        if (out_ch.out_green !== want.green)
          report_mismatch("out_green", int'(out_ch.out_green), int'(want.green));
        if (out_ch.out_red !== want.red)
          report_mismatch("out_red", int'(out_ch.out_red), int'(want.red));
        if (out_ch.out_alpha !== want.alpha)
          report_mismatch("out_alpha", int'(out_ch.out_alpha), int'(want.alpha));
        if (out_ch.out_inside !== want.in_canvas)
          report_mismatch("out_inside", int'(out_ch.out_inside), int'(want.in_canvas));
      end
    end
  end

  // End the run if no channel moves for too long; the reset sweep is the
  // longest legal quiet stretch.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] timeout: no item moved for %0d cycles", $realtime, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready, a long hold-off on request, none while steady
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and register writer; all of them start and end on a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_item(input bcc_item_t it);
    in_ch.valid  <= 1'b1;
    in_ch.action <= it.action;
    in_ch.pos_x  <= it.pos_x;
    in_ch.pos_y  <= it.pos_y;
    in_ch.blue   <= it.blue;
    in_ch.green  <= it.green;
    in_ch.red    <= it.red;
    in_ch.alpha  <= it.alpha;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_action(it);
    @(negedge clk);
    // Leave valid high for the next item unless a gap is drawn.
    if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic issue(input logic [ACT_W-1:0] act, input int x, input int y,
                       input logic [PIX_W-1:0] argb);
    bcc_item_t it;
    it.action = act;
    it.pos_x  = x[POS_W-1:0];
    it.pos_y  = y[POS_W-1:0];
    {it.alpha, it.red, it.green, it.blue} = argb;
    send_item(it);
  endtask

  // Pause the sender until every read is answered and the engine is empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_reads.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    apply_reg(idx, data);
    @(negedge clk);
  endtask

  // Settle, then write all registers, with random bits above each field that leaves room.
  task automatic configure(input int w, input int h, input int left, input int top,
                           input logic [KEY_W-1:0] key, input bit key_on,
                           input bit opaque);
    int span;
    settle();
    write_reg(CFG_CANVAS_WIDTH,  {15'($urandom), 9'(w)});
    write_reg(CFG_CANVAS_HEIGHT, {15'($urandom), 9'(h)});
    write_reg(CFG_FRAME_LEFT,    {8'($urandom), 16'(left)});
    write_reg(CFG_FRAME_TOP,     {8'($urandom), 16'(top)});
    write_reg(CFG_KEY_COLOR,     key);
    write_reg(CFG_KEY_ENABLE,    {23'($urandom), key_on});
    write_reg(CFG_FORCE_OPAQUE,  {23'($urandom), opaque});
    cfg_ch.valid <= 1'b0;
    // Keep random targets in a small window so reads meet written pixels.
    span  = (width_in_use > CANVAS_W) ? CANVAS_W : width_in_use;
    hot_x = (span > 12) ? 12 : span;
    span  = (height_in_use > CANVAS_H) ? CANVAS_H : height_in_use;
    hot_y = (span > 12) ? 12 : span;
  endtask

  // Mostly on-canvas actions; a few land anywhere in the 13-bit space.
  function automatic bcc_item_t random_item();
    bcc_item_t it;
    int        pick;
    int        tx;
    int        ty;
    pick = $urandom_range(0, 99);
    it.action = (pick < 45) ? ACT_COMPOSITE :
                (pick < 55) ? ACT_CLEAR :
                (pick < 96) ? ACT_READ : ACT_UNUSED;
    tx = $urandom_range(0, hot_x);
    ty = $urandom_range(0, hot_y);
    if (it.action != ACT_READ) begin
      tx -= origin_x;   // frame-local position that hits the target
      ty -= origin_y;
    end
    if (tx < 0 || tx >= (1 << POS_W) || $urandom_range(0, 99) < 8)
      tx = $urandom_range(0, (1 << POS_W) - 1);
    if (ty < 0 || ty >= (1 << POS_W) || $urandom_range(0, 99) < 8)
      ty = $urandom_range(0, (1 << POS_W) - 1);
    it.pos_x = tx[POS_W-1:0];
    it.pos_y = ty[POS_W-1:0];
    pick = $urandom_range(0, 99);
    it.alpha = (pick < 15) ? 8'd0 : (pick < 40) ? CH_MAX : 8'($urandom_range(1, 254));
    // Paint the key colour now and then so the key test fires.
    if (pick >= 15 && pick < 25 && chroma_key_on)
      {it.red, it.green, it.blue} = chroma_key;
    else
      {it.red, it.green, it.blue} = 24'($urandom);
    return it;
  endfunction

  // Send random items until count of them carry an action code other than the unused one.
  task automatic run_traffic(input int count);
    bcc_item_t it;
    int        done;
    done = 0;
    while (done < count) begin
      it = random_item();
      send_item(it);
      if (it.action != ACT_UNUSED) done++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset values: full 256 x 256 canvas, no offset, all pixels zero.
  task automatic test_reset_state();
    issue(ACT_READ, 0, 0, '0);
    issue(ACT_READ, 255, 255, '0);
    issue(ACT_READ, 256, 0, '0);
    issue(ACT_READ, 8191, 8191, '0);
    issue(ACT_COMPOSITE, 0, 0, 32'hFF_80_40_20);     // opaque: copy
    issue(ACT_COMPOSITE, 0, 0, 32'h80_30_20_10);     // half alpha: blend
    issue(ACT_COMPOSITE, 0, 0, 32'h00_FF_FF_FF);     // zero alpha: skip
    issue(ACT_COMPOSITE, 0, 0, 32'h01_FF_FF_FF);
    issue(ACT_READ, 0, 0, '0);
    issue(ACT_COMPOSITE, 255, 255, 32'hFF_FF_FF_FF);
    issue(ACT_COMPOSITE, 255, 255, 32'hFE_FF_FF_FF); // colour wraps past 255
    issue(ACT_READ, 255, 255, '0);
    issue(ACT_UNUSED, 0, 0, 32'hFF_00_00_00);        // must be ignored
    issue(ACT_READ, 0, 0, '0);
    issue(ACT_CLEAR, 0, 0, '0);
    issue(ACT_READ, 0, 0, '0);
  endtask

  // Smallest, zero and oversized canvas, extreme frame offsets, bad index.
  task automatic test_canvas_limits();
    configure(1, 1, -32768, 32767, '0, 1'b0, 1'b0);
    issue(ACT_COMPOSITE, 0, 0, 32'hFF_11_22_33);     // far off canvas: drop
    configure(1, 1, 32767, -32768, '0, 1'b0, 1'b0);
    issue(ACT_CLEAR, 8191, 8191, '0);
    configure(1, 1, 0, 0, '0, 1'b0, 1'b0);
    issue(ACT_COMPOSITE, 0, 0, 32'hFF_11_22_33);
    issue(ACT_READ, 1, 0, '0);
    configure(0, 256, 0, 0, '0, 1'b0, 1'b0);
    issue(ACT_READ, 0, 0, '0);                       // zero width: nothing on canvas
    configure(511, 256, 0, 0, '0, 1'b0, 1'b0);
    issue(ACT_READ, 255, 3, '0);
    issue(ACT_READ, 256, 3, '0);
    settle();
    write_reg(CFG_UNUSED_IDX, 24'($urandom));
    cfg_ch.valid <= 1'b0;
    issue(ACT_READ, 0, 0, '0);
  endtask

  // Force-opaque and colour key on readout, including off-canvas reads.
  task automatic test_readout_modes();
    configure(256, 256, 0, 0, 24'h123456, 1'b1, 1'b0);
    issue(ACT_COMPOSITE, 2, 2, 32'hFF_12_34_56);
    issue(ACT_READ, 2, 2, '0);
    configure(256, 256, 0, 0, 24'h123456, 1'b1, 1'b1);
    issue(ACT_READ, 2, 2, '0);
    configure(256, 256, 0, 0, 24'hFFFFFF, 1'b1, 1'b1);
    issue(ACT_READ, 3, 3, '0);
    issue(ACT_READ, 256, 3, '0);
    configure(256, 256, 0, 0, 24'h000000, 1'b1, 1'b1);
    issue(ACT_READ, 3, 3, '0);
  endtask

  // Random traffic over a series of canvas and readout settings.
  task automatic test_random_traffic();
    configure(8, 8, 0, 0, 24'($urandom), 1'b0, 1'b0);
    run_traffic(250);
    configure(16, 5, -3, 2, 24'($urandom), 1'b1, 1'b0);
    run_traffic(250);
    configure(1, 1, 5, -7, 24'($urandom), 1'b1, 1'b1);
    run_traffic(150);
    configure(300, 256, 0, 0, 24'($urandom), 1'b1, 1'b1);
    run_traffic(250);
    configure(12, 0, 1, 1, 24'($urandom), 1'b0, 1'b1);
    run_traffic(60);
    configure(256, 256, -100, -40, 24'($urandom), 1'b0, 1'b0);
    run_traffic(250);
    // One long stretch with no idling on either side.
    configure(12, 12, 0, 0, 24'($urandom), 1'b1, 1'b0);
    steady_flow = 1'b1;
    run_traffic(250);
    steady_flow = 1'b0;
    configure(20, 3, -2, 0, 24'($urandom), 1'b1, 1'b0);
    run_traffic(320);
  endtask

  // Receiver holds off while the sender keeps offering: the block must fill
  // up, stall its input and lose nothing.
  task automatic test_output_backpressure();
    configure(8, 8, 0, 0, 24'($urandom), 1'b0, 1'b0);
    steady_flow  = 1'b1;
    hold_request = HOLD_OFF_CYCLES;
    run_traffic(150);
    steady_flow = 1'b0;
    settle();
  endtask

  initial begin : run
    foreach (pixel_mem[i]) pixel_mem[i] = '0;
    width_in_use   = CANVAS_W;
    height_in_use  = CANVAS_H;
    origin_x       = 0;
    origin_y       = 0;
    chroma_key     = '0;
    chroma_key_on  = 1'b0;
    opaque_readout = 1'b0;
    mismatches     = 0;
    steady_flow    = 1'b0;
    hold_request   = 0;
    hot_x          = 12;
    hot_y          = 12;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = '0;
    in_ch.pos_x  = '0;
    in_ch.pos_y  = '0;
    in_ch.blue   = '0;
    in_ch.green  = '0;
    in_ch.red    = '0;
    in_ch.alpha  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr  = '0;
    cfg_ch.data  = '0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // The first item waits out the clearing sweep on in_ch.ready.
    test_reset_state();
    test_canvas_limits();
    test_readout_modes();
    test_random_traffic();
    test_output_backpressure();

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bcc_pkg.sv
rtl/bcc_in_if.sv
rtl/bcc_out_if.sv
rtl/bcc_cfg_if.sv
rtl/bcc_front.sv
rtl/bcc_queue.sv
rtl/bcc_back.sv
rtl/bgra_canvas_compositor_core.sv
tb/bgra_canvas_compositor_core_test.sv
